// ----- hw/rtl/canonical_huffman_bit_decoder_core_defines.svh -----
// Assertion macros used by the decoder back end (chbd_back).
`ifndef CANONICAL_HUFFMAN_BIT_DECODER_CORE_DEFINES_SVH
`define CANONICAL_HUFFMAN_BIT_DECODER_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CHBD_ASSERT_NOW(lbl, pre, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (cond)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CHBD_ASSERT_NEXT(lbl, pre, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (cond)) \
		else $error(msg);

`endif

// ----- hw/rtl/chbd_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package chbd_pkg;

	localparam int MAX_CODE_BITS_DEF = 16;
	localparam int SYMBOL_DEPTH_DEF  = 256;

	localparam int FUNC_W      = 2;
	localparam int SLOT_W      = 8;
	localparam int VALUE_W     = 8;
	localparam int COUNT_W     = 8;
	localparam int CODE_LEN_W  = 5;
	localparam int NUM_LENGTHS = 16;
	localparam int COUNT_IDX_W = 4;
	localparam int START_W     = 17;
	localparam int BASE_W      = 9;
	localparam int IDX_W       = BASE_W + 1;

	localparam logic [START_W-1:0] START_MAX = {START_W{1'b1}};
	localparam logic [BASE_W-1:0]  BASE_MAX  = {BASE_W{1'b1}};

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = 2;

	localparam logic [FUNC_W-1:0] FUNC_LOAD_COUNT  = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_LOAD_SYMBOL = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_DECODE_BIT  = 2'd2;

	typedef enum logic [1:0] {
		OP_COUNT   = 2'd0,
		OP_SYMBOL  = 2'd1,
		OP_RESTART = 2'd2,
		OP_BIT     = 2'd3
	} op_t;

	typedef struct packed {
		op_t                op;
		logic [SLOT_W-1:0]  slot;
		logic [VALUE_W-1:0] value;
		logic               code_bit;
	} item_t;

	typedef struct packed {
		logic  valid;
		item_t item;
	} head_t;

endpackage

`default_nettype wire

// ----- hw/rtl/canonical_huffman_bit_decoder_core.sv -----
// An accepted decode beat reaches its result beat through these registered steps
// (queue entry, code match against the running start, symbol memory read).
// Throughput: one beat per cycle unless stalled; start/base registers update per bit.
// Load beats and bits that do not end a code produce no result beat.
// Reset (arst_n low, asynchronous): code counts cleared, decoder restarted, queue and
// pipeline emptied; the symbol memory is not cleared and holds no valid data until loaded.
`timescale 1ns / 1ps
`default_nettype none

module canonical_huffman_bit_decoder_core #(
	parameter int MAX_CODE_BITS = chbd_pkg::MAX_CODE_BITS_DEF,
	parameter int SYMBOL_DEPTH  = chbd_pkg::SYMBOL_DEPTH_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            in_valid,
	output logic                                 in_stall,
	input  wire logic [chbd_pkg::FUNC_W-1:0]     func,
	input  wire logic [chbd_pkg::SLOT_W-1:0]     slot,
	input  wire logic [chbd_pkg::VALUE_W-1:0]    load_value,
	input  wire logic                            code_bit,
	output logic                                 out_valid,
	input  wire logic                            out_stall,
	output logic [chbd_pkg::VALUE_W-1:0]         symbol,
	output logic [chbd_pkg::CODE_LEN_W-1:0]      code_length,
	output logic                                 status
);

	logic             q_full;
	logic             push;
	logic             pop;
	chbd_pkg::item_t  push_item;
	chbd_pkg::head_t  head;

	chbd_front #(
		.SYMBOL_DEPTH(SYMBOL_DEPTH)
	) u_front (
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.func      (func),
		.slot      (slot),
		.load_value(load_value),
		.code_bit  (code_bit),
		.q_full    (q_full),
		.push      (push),
		.item      (push_item)
	);

	chbd_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_item(push_item),
		.full     (q_full),
		.pop      (pop),
		.head     (head)
	);

	chbd_back #(
		.MAX_CODE_BITS(MAX_CODE_BITS),
		.SYMBOL_DEPTH (SYMBOL_DEPTH)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.symbol     (symbol),
		.code_length(code_length),
		.status     (status)
	);

endmodule

`default_nettype wire

// ----- hw/rtl/chbd_front.sv -----
`timescale 1ns / 1ps
`default_nettype none

module chbd_front #(
	parameter int SYMBOL_DEPTH = chbd_pkg::SYMBOL_DEPTH_DEF
) (
	input  wire logic                         in_valid,
	output logic                              in_stall,
	input  wire logic [chbd_pkg::FUNC_W-1:0]  func,
	input  wire logic [chbd_pkg::SLOT_W-1:0]  slot,
	input  wire logic [chbd_pkg::VALUE_W-1:0] load_value,
	input  wire logic                         code_bit,
	input  wire logic                         q_full,
	output logic                              push,
	output chbd_pkg::item_t                   item
);

	logic keep;
	logic count_ok;
	logic symbol_ok;

	assign count_ok  = slot < chbd_pkg::SLOT_W'(chbd_pkg::NUM_LENGTHS);
	assign symbol_ok = {1'b0, slot} < (chbd_pkg::SLOT_W + 1)'(SYMBOL_DEPTH);

	// Loads with a slot out of range still restart the decoder.
	always_comb begin
		keep          = 1'b1;
		item.op       = chbd_pkg::OP_RESTART;
		item.slot     = slot;
		item.value    = load_value;
		item.code_bit = code_bit;
		case (func)
			chbd_pkg::FUNC_LOAD_COUNT: begin
				item.op = count_ok ? chbd_pkg::OP_COUNT : chbd_pkg::OP_RESTART;
			end
			chbd_pkg::FUNC_LOAD_SYMBOL: begin
				item.op = symbol_ok ? chbd_pkg::OP_SYMBOL : chbd_pkg::OP_RESTART;
			end
			chbd_pkg::FUNC_DECODE_BIT: begin
				item.op = chbd_pkg::OP_BIT;
			end
			default: begin
				keep = 1'b0;
			end
		endcase
	end

	assign in_stall = q_full;
	assign push     = in_valid && !q_full && keep;

endmodule

`default_nettype wire

// ----- hw/rtl/chbd_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none

module chbd_queue (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            push,
	input  wire chbd_pkg::item_t push_item,
	output logic                 full,
	input  wire logic            pop,
	output chbd_pkg::head_t      head
);

	chbd_pkg::item_t                 entry_q [chbd_pkg::QUEUE_DEPTH];
	logic [chbd_pkg::QPTR_W-1:0]     wr_ptr_q;
	logic [chbd_pkg::QPTR_W-1:0]     rd_ptr_q;
	logic [chbd_pkg::QPTR_W:0]       fill_q;

	assign full = fill_q == (chbd_pkg::QPTR_W + 1)'(chbd_pkg::QUEUE_DEPTH);
	assign head = '{valid: fill_q != '0, item: entry_q[rd_ptr_q]};

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + chbd_pkg::QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + chbd_pkg::QPTR_W'(1);
			end
			if (push && !pop) begin
				fill_q <= fill_q + (chbd_pkg::QPTR_W + 1)'(1);
			end else if (pop && !push) begin
				fill_q <= fill_q - (chbd_pkg::QPTR_W + 1)'(1);
			end
		end
	end

endmodule

`default_nettype wire

// ----- hw/rtl/chbd_back.sv -----
`timescale 1ns / 1ps
`default_nettype none

`include "canonical_huffman_bit_decoder_core_defines.svh"

module chbd_back #(
	parameter int MAX_CODE_BITS = chbd_pkg::MAX_CODE_BITS_DEF,
	parameter int SYMBOL_DEPTH  = chbd_pkg::SYMBOL_DEPTH_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire chbd_pkg::head_t                 head,
	output logic                                 pop,
	output logic                                 out_valid,
	input  wire logic                            out_stall,
	output logic [chbd_pkg::VALUE_W-1:0]         symbol,
	output logic [chbd_pkg::CODE_LEN_W-1:0]      code_length,
	output logic                                 status
);

	localparam int SHIFT_W = $clog2(MAX_CODE_BITS);
	localparam int SPAN_W  = chbd_pkg::COUNT_W + MAX_CODE_BITS;
	localparam int SUM_W   = ((SPAN_W > chbd_pkg::START_W) ? SPAN_W : chbd_pkg::START_W) + 1;
	localparam int AW      = $clog2(SYMBOL_DEPTH);

	// Decoder state.
	logic [chbd_pkg::COUNT_W-1:0] counts_q [chbd_pkg::NUM_LENGTHS];
	logic [MAX_CODE_BITS-1:0]     partial_q;
	logic [SHIFT_W-1:0]           taken_q;
	logic [chbd_pkg::START_W-1:0] start_q;
	logic [chbd_pkg::BASE_W-1:0]  base_q;
	logic [chbd_pkg::VALUE_W-1:0] mem [SYMBOL_DEPTH];

	// Stage 1: code classified, symbol position still to resolve.
	logic                            valid_s1;
	logic                            fail_s1;
	logic [chbd_pkg::CODE_LEN_W-1:0] len_s1;
	logic [MAX_CODE_BITS-1:0]        diff_s1;
	logic [SHIFT_W-1:0]              shift_s1;
	logic [chbd_pkg::BASE_W-1:0]     base_s1;

	// Stage 2: result register.
	logic                            valid_s2;
	logic                            err_s2;
	logic [chbd_pkg::CODE_LEN_W-1:0] len_s2;
	logic [chbd_pkg::VALUE_W-1:0]    rdata_s2;

	logic                            en_s2;
	logic                            en_s1;
	logic                            is_bit;
	logic                            is_load;
	logic [chbd_pkg::CODE_LEN_W-1:0] size;
	logic [SHIFT_W-1:0]              shift;
	logic [MAX_CODE_BITS-1:0]        partial_n;
	logic [chbd_pkg::COUNT_W-1:0]    count;
	logic [SUM_W-1:0]                span;
	logic [SUM_W-1:0]                next_start;
	logic [MAX_CODE_BITS-1:0]        diff;
	logic                            hit;
	logic                            last;
	logic                            emit;
	logic [chbd_pkg::START_W-1:0]    start_sat;
	logic [chbd_pkg::IDX_W-1:0]      base_sum;
	logic [chbd_pkg::BASE_W-1:0]     base_sat;
	logic [chbd_pkg::IDX_W-1:0]      index;
	logic                            in_range;

	assign en_s2   = !valid_s2 || !out_stall;
	assign en_s1   = !valid_s1 || en_s2;
	assign pop     = head.valid && en_s1;
	assign is_bit  = head.item.op == chbd_pkg::OP_BIT;
	assign is_load = pop && !is_bit;

	assign size      = chbd_pkg::CODE_LEN_W'(taken_q) + chbd_pkg::CODE_LEN_W'(1);
	assign shift     = SHIFT_W'(MAX_CODE_BITS - 1) - taken_q;
	assign partial_n = partial_q | (MAX_CODE_BITS'(head.item.code_bit) << shift);
	assign count     = counts_q[chbd_pkg::COUNT_IDX_W'(taken_q)];
	assign span      = SUM_W'(count) << shift;
	assign next_start = SUM_W'(start_q) + span;
	assign diff      = partial_n - start_q[MAX_CODE_BITS-1:0];
	assign hit       = (SUM_W'(partial_n) >= SUM_W'(start_q)) && (SUM_W'(partial_n) < next_start);
	assign last      = taken_q == SHIFT_W'(MAX_CODE_BITS - 1);
	assign emit      = pop && is_bit && (hit || last);

	// Oversubscribed tables saturate so the start never wraps back into range.
	assign start_sat = (next_start > SUM_W'(chbd_pkg::START_MAX)) ? chbd_pkg::START_MAX
		: next_start[chbd_pkg::START_W-1:0];
	assign base_sum  = chbd_pkg::IDX_W'(base_q) + chbd_pkg::IDX_W'(count);
	assign base_sat  = (base_sum > chbd_pkg::IDX_W'(chbd_pkg::BASE_MAX)) ? chbd_pkg::BASE_MAX
		: base_sum[chbd_pkg::BASE_W-1:0];

	assign index    = chbd_pkg::IDX_W'(base_s1)
		+ chbd_pkg::IDX_W'(chbd_pkg::COUNT_W'(diff_s1 >> shift_s1));
	assign in_range = index < chbd_pkg::IDX_W'(SYMBOL_DEPTH);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < chbd_pkg::NUM_LENGTHS; i++) begin
				counts_q[i] <= '0;
			end
			partial_q <= '0;
			taken_q   <= '0;
			start_q   <= '0;
			base_q    <= '0;
		end else if (pop) begin
			if (is_bit && !emit) begin
				partial_q <= partial_n;
				taken_q   <= taken_q + SHIFT_W'(1);
				start_q   <= start_sat;
				base_q    <= base_sat;
			end else begin
				partial_q <= '0;
				taken_q   <= '0;
				start_q   <= '0;
				base_q    <= '0;
			end
			if (head.item.op == chbd_pkg::OP_COUNT) begin
				counts_q[head.item.slot[chbd_pkg::COUNT_IDX_W-1:0]] <= head.item.value;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (en_s1) begin
				valid_s1 <= emit;
			end
			if (en_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			fail_s1  <= !hit;
			len_s1   <= size;
			diff_s1  <= diff;
			shift_s1 <= shift;
			base_s1  <= base_q;
		end
		if (en_s2 && valid_s1) begin
			err_s2 <= fail_s1 || !in_range;
			len_s2 <= len_s1;
		end
	end

	// A symbol load behind a decode in stage 1 writes in the same cycle as
	// that decode reads, and the read returns the older contents.
	always_ff @(posedge clk) begin
		if (en_s2 && valid_s1 && !fail_s1 && in_range) begin
			rdata_s2 <= mem[index[AW-1:0]];
		end
		if (pop && head.item.op == chbd_pkg::OP_SYMBOL) begin
			mem[head.item.slot[AW-1:0]] <= head.item.value;
		end
	end

	assign out_valid   = valid_s2;
	assign symbol      = err_s2 ? '0 : rdata_s2;
	assign code_length = len_s2;
	assign status      = err_s2;

	`CHBD_ASSERT_NOW(a_pop_nonempty, pop, head.valid, "pop from an empty queue")
	`CHBD_ASSERT_NOW(a_fail_len, valid_s1 && fail_s1,
		len_s1 == chbd_pkg::CODE_LEN_W'(MAX_CODE_BITS), "no-match result with short length")
	`CHBD_ASSERT_NEXT(a_bit_advance, pop && is_bit && !emit,
		taken_q == $past(taken_q) + SHIFT_W'(1), "code length did not advance")
	`CHBD_ASSERT_NEXT(a_load_restart, is_load,
		taken_q == '0 && partial_q == '0, "load did not restart the decoder")

endmodule

`default_nettype wire

// ----- tb/sv/canonical_huffman_bit_decoder_core_test.sv -----
`timescale 1ns / 1ps

module canonical_huffman_bit_decoder_core_test;

	localparam int CODE_BITS = chbd_pkg::MAX_CODE_BITS_DEF;
	localparam int SYM_DEPTH = chbd_pkg::SYMBOL_DEPTH_DEF;
	localparam logic [chbd_pkg::FUNC_W-1:0] FUNC_UNUSED = 2'd3;
	localparam int RANDOM_BEATS = 2000;
	localparam int STALL_LIMIT = 1000;
	localparam int DRAIN_CYCLES = 20;

	typedef struct packed {
		logic [chbd_pkg::VALUE_W-1:0]    sym;
		logic [chbd_pkg::CODE_LEN_W-1:0] len;
		logic                            miss;
	} decode_result_t;

	logic                            clk;
	logic                            arst_n;
	logic                            in_valid;
	logic                            in_stall;
	logic [chbd_pkg::FUNC_W-1:0]     func;
	logic [chbd_pkg::SLOT_W-1:0]     slot;
	logic [chbd_pkg::VALUE_W-1:0]    load_value;
	logic                            code_bit;
	logic                            out_valid;
	logic                            out_stall;
	logic [chbd_pkg::VALUE_W-1:0]    symbol;
	logic [chbd_pkg::CODE_LEN_W-1:0] code_length;
	logic                            status;

	// Our own copy of the code table and of the running decode state.
	logic [chbd_pkg::COUNT_W-1:0]    len_count [chbd_pkg::NUM_LENGTHS];
	logic [chbd_pkg::VALUE_W-1:0]    sym_mem [SYM_DEPTH];
	logic [CODE_BITS-1:0]            acc_code;
	logic [chbd_pkg::CODE_LEN_W-1:0] acc_len;
	logic [chbd_pkg::START_W-1:0]    run_start;
	logic [chbd_pkg::BASE_W-1:0]     run_base;

	decode_result_t expected_symbols [$];
	int mismatches;
	int beats_sent;
	int stuck_cycles;
	bit no_idle;

	canonical_huffman_bit_decoder_core dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.func        (func),
		.slot        (slot),
		.load_value  (load_value),
		.code_bit    (code_bit),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.symbol      (symbol),
		.code_length (code_length),
		.status      (status)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	function automatic int draw_gap();
		return no_idle ? 0 : $urandom_range(0, 5);
	endfunction

	function automatic void restart_decoder();
		acc_code = '0;
		acc_len = '0;
		run_start = '0;
		run_base = '0;
	endfunction

	function automatic void push_result(input logic [chbd_pkg::VALUE_W-1:0] sym,
			input int unsigned len, input logic miss);
		decode_result_t res;
		res.sym = sym;
		res.len = chbd_pkg::CODE_LEN_W'(len);
		res.miss = miss;
		expected_symbols.push_back(res);
		restart_decoder();
	endfunction

	// Applies one accepted beat to the table and the partial code.
	function automatic void advance_decoder(input logic [chbd_pkg::FUNC_W-1:0] f,
			input logic [chbd_pkg::SLOT_W-1:0] s, input logic [chbd_pkg::VALUE_W-1:0] v,
			input logic b);
		int unsigned size;
		int unsigned shift;
		int unsigned count;
		int unsigned next_start;
		int unsigned next_base;
		int unsigned index;
		case (f)
			chbd_pkg::FUNC_LOAD_COUNT: begin
				if (s < chbd_pkg::NUM_LENGTHS)
					len_count[s[chbd_pkg::COUNT_IDX_W-1:0]] = v;
				restart_decoder();
			end
			chbd_pkg::FUNC_LOAD_SYMBOL: begin
				sym_mem[s] = v;
				restart_decoder();
			end
			chbd_pkg::FUNC_DECODE_BIT: begin
				size = acc_len + 1;
				shift = CODE_BITS - size;
				acc_code = acc_code | (CODE_BITS'(b) << shift);
				count = len_count[chbd_pkg::COUNT_IDX_W'(size - 1)];
				next_start = run_start + (count << shift);
				if (acc_code >= run_start && acc_code < next_start) begin
					index = run_base + ((acc_code - run_start) >> shift);
					if (index >= SYM_DEPTH)
						push_result('0, size, 1'b1);
					else
						push_result(sym_mem[chbd_pkg::SLOT_W'(index)], size, 1'b0);
				end else if (size >= CODE_BITS) begin
					push_result('0, size, 1'b1);
				end else begin
					next_base = run_base + count;
					run_start = (next_start > chbd_pkg::START_MAX) ? chbd_pkg::START_MAX
						: chbd_pkg::START_W'(next_start);
					run_base = (next_base > chbd_pkg::BASE_MAX) ? chbd_pkg::BASE_MAX
						: chbd_pkg::BASE_W'(next_base);
					acc_len = chbd_pkg::CODE_LEN_W'(size);
				end
			end
			default: ;
		endcase
	endfunction

	task automatic send_beat(input logic [chbd_pkg::FUNC_W-1:0] f,
			input logic [chbd_pkg::SLOT_W-1:0] s, input logic [chbd_pkg::VALUE_W-1:0] v,
			input logic b);
		int gap;
		gap = draw_gap();
		if ($urandom_range(0, 99) == 0)
			no_idle = !no_idle;
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		func <= f;
		slot <= s;
		load_value <= v;
		code_bit <= b;
		do @(posedge clk); while (in_stall !== 1'b0);
		advance_decoder(f, s, v, b);
		if (f != FUNC_UNUSED)
			beats_sent++;
	endtask

	task automatic send_noise_bit();
		send_beat(chbd_pkg::FUNC_DECODE_BIT, chbd_pkg::SLOT_W'($urandom),
			chbd_pkg::VALUE_W'($urandom), 1'($urandom));
	endtask

	// Sends the canonical code of the given length and offset under the current table.
	task automatic send_code(input int unsigned length, input int unsigned offset);
		int unsigned first_code;
		first_code = 0;
		for (int l = 1; l < length; l++)
			first_code += len_count[chbd_pkg::COUNT_IDX_W'(l - 1)] << (CODE_BITS - l);
		first_code += offset << (CODE_BITS - length);
		if (first_code >= (1 << CODE_BITS))
			return;
		for (int i = 0; i < length; i++)
			send_beat(chbd_pkg::FUNC_DECODE_BIT, chbd_pkg::SLOT_W'($urandom),
				chbd_pkg::VALUE_W'($urandom), first_code[CODE_BITS - 1 - i]);
	endtask

	task automatic send_random_code();
		int unsigned lens [$];
		int unsigned pick;
		for (int l = 1; l <= chbd_pkg::NUM_LENGTHS; l++)
			if (len_count[chbd_pkg::COUNT_IDX_W'(l - 1)] != 0)
				lens.push_back(l);
		if (lens.size() == 0) begin
			send_noise_bit();
			return;
		end
		pick = lens[$urandom_range(0, lens.size() - 1)];
		send_code(pick,
			$urandom_range(0, len_count[chbd_pkg::COUNT_IDX_W'(pick - 1)] - 1));
	endtask

	// Mostly tables that respect the code space, some oversubscribed, some sparse.
	task automatic load_random_table();
		int unsigned room;
		int unsigned lim;
		int unsigned c;
		int kind;
		kind = $urandom_range(0, 9);
		room = 2;
		for (int l = 0; l < chbd_pkg::NUM_LENGTHS; l++) begin
			if (kind < 6) begin
				lim = (room > 255) ? 255 : room;
				c = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, lim);
				room = (room - c) * 2;
			end else if (kind < 8) begin
				c = $urandom_range(0, 255);
			end else begin
				c = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 255) : 0;
			end
			send_beat(chbd_pkg::FUNC_LOAD_COUNT, chbd_pkg::SLOT_W'(l),
				chbd_pkg::VALUE_W'(c), 1'($urandom));
		end
	endtask

	task automatic test_empty_table();
		// No counts loaded: sixteen bits end in a miss, an unused beat in between changes nothing.
		for (int i = 0; i < CODE_BITS; i++) begin
			if (i == 7)
				send_beat(FUNC_UNUSED, chbd_pkg::SLOT_W'($urandom),
					chbd_pkg::VALUE_W'($urandom), 1'($urandom));
			send_beat(chbd_pkg::FUNC_DECODE_BIT, chbd_pkg::SLOT_W'($urandom),
				chbd_pkg::VALUE_W'($urandom), i[0]);
		end
	endtask

	task automatic test_list_overflow();
		// 255 codes of length 8 fill the list up to position 254; the second
		// length 9 code points past the end.
		send_beat(chbd_pkg::FUNC_LOAD_COUNT, 8'd7, 8'd255, 1'b0);
		send_beat(chbd_pkg::FUNC_LOAD_COUNT, 8'd8, 8'd2, 1'b1);
		send_beat(chbd_pkg::FUNC_LOAD_SYMBOL, 8'd255, 8'hC3, 1'b0);
		send_code(9, 1);
	endtask

	task automatic test_full_code_space();
		// Lengths 1, 2, 3, 3 use the whole code space, so the last start is 2**16.
		send_beat(chbd_pkg::FUNC_LOAD_COUNT, 8'd0, 8'd1, 1'b1);
		send_beat(chbd_pkg::FUNC_LOAD_COUNT, 8'd1, 8'd1, 1'b0);
		send_beat(chbd_pkg::FUNC_LOAD_COUNT, 8'd2, 8'd2, 1'b1);
		send_beat(chbd_pkg::FUNC_LOAD_SYMBOL, 8'd0, 8'h00, 1'b1);
		send_beat(chbd_pkg::FUNC_LOAD_SYMBOL, 8'd3, 8'hFF, 1'b0);
		send_code(1, 0);
		send_code(3, 1);
		// Loads to an out-of-range count slot are dropped but still restart the code.
		send_beat(chbd_pkg::FUNC_DECODE_BIT, 8'hFF, 8'hFF, 1'b1);
		send_beat(chbd_pkg::FUNC_LOAD_COUNT, 8'd16, 8'h7E, 1'b0);
		send_beat(chbd_pkg::FUNC_DECODE_BIT, 8'h00, 8'h00, 1'b0);
		send_beat(chbd_pkg::FUNC_DECODE_BIT, 8'h55, 8'hAA, 1'b1);
		send_beat(chbd_pkg::FUNC_LOAD_COUNT, 8'hFF, 8'h81, 1'b1);
		send_code(3, 1);
	endtask

	task automatic test_random_streams();
		int unsigned roll;
		for (int i = 0; i < SYM_DEPTH; i++)
			send_beat(chbd_pkg::FUNC_LOAD_SYMBOL, chbd_pkg::SLOT_W'(i),
				chbd_pkg::VALUE_W'($urandom), 1'($urandom));
		while (beats_sent < RANDOM_BEATS) begin
			load_random_table();
			repeat ($urandom_range(5, 40)) begin
				roll = $urandom_range(0, 99);
				if (roll < 80)
					send_random_code();
				else if (roll < 88)
					repeat ($urandom_range(1, 6)) send_noise_bit();
				else if (roll < 92)
					send_beat(FUNC_UNUSED, chbd_pkg::SLOT_W'($urandom),
						chbd_pkg::VALUE_W'($urandom), 1'($urandom));
				else if (roll < 95)
					send_beat(chbd_pkg::FUNC_LOAD_COUNT,
						chbd_pkg::SLOT_W'($urandom_range(chbd_pkg::NUM_LENGTHS, 255)),
						chbd_pkg::VALUE_W'($urandom), 1'($urandom));
				else if (roll < 98)
					send_beat(chbd_pkg::FUNC_LOAD_SYMBOL, chbd_pkg::SLOT_W'($urandom),
						chbd_pkg::VALUE_W'($urandom), 1'($urandom));
				else
					repeat (CODE_BITS) send_noise_bit();
			end
		end
	endtask

	initial begin : drive_out_stall
		int hold;
		out_stall = 1'b0;
		forever begin
			// Half the time the stall lands on a result that is already waiting.
			if ($urandom_range(0, 1) == 0)
				while (out_valid !== 1'b1) @(negedge clk);
			hold = draw_gap();
			if (hold > 0) begin
				out_stall <= 1'b1;
				repeat (hold) @(negedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (!(out_valid === 1'b1 && out_stall === 1'b0));
			@(negedge clk);
		end
	end

	always @(posedge clk) begin : check_results
		decode_result_t want;
		if (arst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
			if (expected_symbols.size() == 0) begin
				$display("%0t: unexpected result beat: expected none, actual %02h/%0d/%0d",
					$time, symbol, code_length, status);
				mismatches++;
			end else begin
				want = expected_symbols.pop_front();
				if (symbol !== want.sym) begin
					$display("%0t: symbol mismatch: expected %02h, actual %02h",
						$time, want.sym, symbol);
					mismatches++;
				end
				if (code_length !== want.len) begin
					$display("%0t: code_length mismatch: expected %0d, actual %0d",
						$time, want.len, code_length);
					mismatches++;
				end
				if (status !== want.miss) begin
					$display("%0t: status mismatch: expected %0d, actual %0d",
						$time, want.miss, status);
					mismatches++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
			stuck_cycles = 0;
		else
			stuck_cycles++;
		if (stuck_cycles >= STALL_LIMIT) begin
			$display("%0t: no beat accepted for %0d cycles", $time, STALL_LIMIT);
			$display("FAIL");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		func = chbd_pkg::FUNC_DECODE_BIT;
		slot = '0;
		load_value = '0;
		code_bit = 1'b0;
		mismatches = 0;
		beats_sent = 0;
		stuck_cycles = 0;
		no_idle = 1'b0;
		foreach (len_count[i])
			len_count[i] = '0;
		foreach (sym_mem[i])
			sym_mem[i] = '0;
		restart_decoder();
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_empty_table();
		test_list_overflow();
		test_full_code_space();
		test_random_streams();

		@(negedge clk);
		in_valid <= 1'b0;
		while (expected_symbols.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
